### src/iterative_linear_solver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the iterative linear solver
// Shared wrappers so assertions can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef ITERATIVE_LINEAR_SOLVER_MACROS_SVH
`define ITERATIVE_LINEAR_SOLVER_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that a property holds on every clock edge outside reset.
`define ILS_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checks that a condition never occurs outside reset.
`define ILS_ASSERT_NEVER(lbl, clock, reset, cond, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define ILS_ASSERT(lbl, clock, reset, prop, msg)
`define ILS_ASSERT_NEVER(lbl, clock, reset, cond, msg)
`endif

`endif

### src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants and codes of the iterative linear solver.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Default build sizes.
  localparam int MAX_UNKNOWNS_DEF = 8;
  localparam int FRAC_BITS_DEF    = 24;

  // Fixed field widths.
  localparam int DATA_W = 32;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS  = 2'd1;
  localparam logic [1:0] OP_SOLVE     = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE      = 2'd0;
  localparam logic [1:0] REG_METHOD    = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;
  localparam logic [1:0] REG_LIMIT     = 2'd3;

  // Configuration reset values.
  localparam logic [3:0]  SIZE_RST   = 4'd4;
  localparam logic [30:0] TOL_RST    = 31'd84;
  localparam logic [15:0] LIMIT_RST  = 16'd1000;

endpackage

### src/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ils_div.sv
// ----------------------------------------------------------------------------
// ils_div
// Radix-2 restoring divider: saturated fixed-point quotient num / den (zero for
// a zero den), truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ils_div import ils_pkg::*; #(
  parameter int NUM_W     = 46,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output logic [DATA_W-1:0]        quot
);

  localparam int WIDE_W = NUM_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DATA_W + 1);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_STEP  = 2'd2;
  localparam logic [1:0] D_FIN   = 2'd3;

  logic [1:0]          state;
  logic [NUM_W-1:0]    nm;
  logic [DATA_W-1:0]   dm;
  logic                neg;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   low;
  logic [DATA_W-1:0]   q;
  logic [CNT_W-1:0]    cnt;
  logic [WIDE_W-1:0]   wide;
  logic [DATA_W:0]     trial;
  logic [DATA_W-1:0]   lim;
  logic [DATA_W-1:0]   qc;

  // Scaled dividend and one restoring step.
  assign wide  = {nm, {FRAC_BITS{1'b0}}};
  assign trial = {rem, low[DATA_W-1]};
  assign lim   = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  assign qc    = (q > lim) ? lim : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      // The quotient is presented in the cycle after the final state.
      done <= (state == D_FIN);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            nm    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dm    <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            neg   <= num[NUM_W-1] ^ den[DATA_W-1];
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          // A quotient of 33 bits or more saturates at once.
          if (dm == '0) begin
            q     <= '0;
            neg   <= 1'b0;
            state <= D_FIN;
          end else if (wide[WIDE_W-1:DATA_W] >= (WIDE_W-DATA_W)'(dm)) begin
            q     <= '1;
            state <= D_FIN;
          end else begin
            rem   <= wide[DATA_W +: DATA_W];
            low   <= wide[DATA_W-1:0];
            q     <= '0;
            cnt   <= CNT_W'(DATA_W);
            state <= D_STEP;
          end
        end
        D_STEP: begin
          if (trial >= {1'b0, dm}) begin
            rem <= DATA_W'(trial - {1'b0, dm});
            q   <= {q[DATA_W-2:0], 1'b1};
          end else begin
            rem <= trial[DATA_W-1:0];
            q   <= {q[DATA_W-2:0], 1'b0};
          end
          low <= {low[DATA_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          quot  <= neg ? DATA_W'(-qc) : qc;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

### src/iterative_linear_solver.sv
// ----------------------------------------------------------------------------
// iterative_linear_solver
// Jacobi / Gauss-Seidel solver over coefficient and estimate RAMs.
// ----------------------------------------------------------------------------
// Loads are accepted while idle. A solve first checks each diagonal entry and
// clears the estimates, then each sweep reads every matrix term through the
// coefficient RAM read port (read, multiply, accumulate) and runs the
// bit-serial divider once per row. Results then follow one per row, each held
// until taken. Reset is synchronous; it clears control and configuration.
// The coefficient and right-hand RAMs hold no defined value until written.
// ----------------------------------------------------------------------------
`include "iterative_linear_solver_macros.svh"

module iterative_linear_solver import ils_pkg::*; #(
  parameter int MAX_UNKNOWNS = MAX_UNKNOWNS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // op[1:0], row[4:2], col[7:5], value[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // index[2:0], solution[34:3], sweeps[50:35], zero
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  localparam int IW    = $clog2(MAX_UNKNOWNS);
  localparam int NW    = $clog2(MAX_UNKNOWNS + 1);
  localparam int AW    = $clog2(MAX_UNKNOWNS * MAX_UNKNOWNS);
  localparam int SUM_W = 64 - FRAC_BITS + $clog2(MAX_UNKNOWNS) + 1;
  localparam int NUM_W = SUM_W + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIAG     = 4'd1;
  localparam logic [3:0] S_DIAG_CHK = 4'd2;
  localparam logic [3:0] S_ROW      = 4'd3;
  localparam logic [3:0] S_TERM_RD  = 4'd4;
  localparam logic [3:0] S_TERM_MUL = 4'd5;
  localparam logic [3:0] S_TERM_ACC = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_CP_RD    = 4'd9;
  localparam logic [3:0] S_CP_WR    = 4'd10;
  localparam logic [3:0] S_TEST     = 4'd11;
  localparam logic [3:0] S_OUT_RD   = 4'd12;
  localparam logic [3:0] S_OUT_LD   = 4'd13;

  // Configuration registers.
  logic [3:0]  matrix_size;
  logic        method;
  logic [30:0] tolerance;
  logic [15:0] iteration_limit;

  // Control and datapath registers.
  logic [3:0]              state;
  logic [NW-1:0]           n_act;
  logic [NW-1:0]           i;
  logic [NW-1:0]           j;
  logic [NW-1:0]           k;
  logic                    zdiag;
  logic                    is_diag;
  logic [DATA_W-1:0]       diag;
  logic signed [63:0]      prod;
  logic signed [SUM_W-1:0] sum;
  logic [DATA_W:0]         change;
  logic [15:0]             sweeps;
  logic [1:0]              status;
  logic [2:0]              out_index;
  logic [DATA_W-1:0]       out_sol;
  logic [15:0]             out_sweeps;
  logic [1:0]              out_status;
  logic                    out_last;

  // Input fields and derived values.
  logic [1:0]              in_op;
  logic [2:0]              in_row;
  logic [2:0]              in_col;
  logic [DATA_W-1:0]       in_value;
  logic                    accept;
  logic                    row_ok;
  logic                    col_ok;
  logic [NW-1:0]           n_eff;
  logic [15:0]             sweeps_inc;
  logic signed [DATA_W:0]  diff;
  logic [DATA_W:0]         dmag;
  logic signed [NUM_W-1:0] div_num;
  logic                    div_done;
  logic [DATA_W-1:0]       div_q;

  // RAM ports.
  logic              coef_we;
  logic [AW-1:0]     coef_waddr;
  logic [AW-1:0]     coef_raddr;
  logic [DATA_W-1:0] coef_q;
  logic              rhs_we;
  logic [DATA_W-1:0] rhs_q;
  logic [IW-1:0]     est_raddr;
  logic              cur_we;
  logic [DATA_W-1:0] cur_wdata;
  logic [DATA_W-1:0] cur_q;
  logic              nxt_we;
  logic [IW-1:0]     nxt_waddr;
  logic [DATA_W-1:0] nxt_wdata;
  logic [DATA_W-1:0] nxt_q;
  logic [DATA_W-1:0] est_q;

  // Unpack the input transaction.
  assign in_op    = s_tdata[1:0];
  assign in_row   = s_tdata[4:2];
  assign in_col   = s_tdata[7:5];
  assign in_value = s_tdata[39:8];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign row_ok   = (int'(in_row) < MAX_UNKNOWNS);
  assign col_ok   = (int'(in_col) < MAX_UNKNOWNS);

  // Size in use, clamped to the built range.
  always_comb begin
    if (matrix_size == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(matrix_size) > MAX_UNKNOWNS) begin
      n_eff = NW'(MAX_UNKNOWNS);
    end else begin
      n_eff = NW'(matrix_size);
    end
  end

  // RAM addressing and write data.
  assign coef_we    = accept && (in_op == OP_LOAD_COEF) && row_ok && col_ok;
  assign coef_waddr = AW'(in_row) * AW'(MAX_UNKNOWNS) + AW'(in_col);
  assign coef_raddr = (state == S_DIAG) ? AW'(k) * AW'(MAX_UNKNOWNS) + AW'(k)
                                        : AW'(i) * AW'(MAX_UNKNOWNS) + AW'(j);
  assign rhs_we     = accept && (in_op == OP_LOAD_RHS) && row_ok;
  assign est_raddr  = (state == S_TERM_RD) ? IW'(j) : IW'(k);
  assign cur_we     = (state == S_DIAG) || (state == S_CP_WR);
  assign cur_wdata  = (state == S_DIAG) ? '0 : nxt_q;
  assign nxt_we     = (state == S_DIAG) || ((state == S_DIV_WAIT) && div_done);
  assign nxt_waddr  = (state == S_DIAG) ? IW'(k) : IW'(i);
  assign nxt_wdata  = (state == S_DIAG) ? '0 : div_q;
  assign est_q      = method ? nxt_q : cur_q;

  ils_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS * MAX_UNKNOWNS)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(in_value),
    .raddr(coef_raddr), .rdata(coef_q)
  );

  ils_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(IW'(in_row)), .wdata(in_value),
    .raddr(IW'(i)), .rdata(rhs_q)
  );

  ils_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_cur (
    .clk(clk), .we(cur_we), .waddr(IW'(k)), .wdata(cur_wdata),
    .raddr(est_raddr), .rdata(cur_q)
  );

  ils_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(est_raddr), .rdata(nxt_q)
  );

  // Row quotient (right side minus off-diagonal sum) over the diagonal.
  assign div_num = NUM_W'($signed(rhs_q)) - NUM_W'(sum);

  ils_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(state == S_DIV_GO), .num(div_num),
    .den($signed(diag)), .done(div_done), .quot(div_q)
  );

  // Change of one entry over a sweep.
  assign diff       = $signed({nxt_q[DATA_W-1], nxt_q}) - $signed({cur_q[DATA_W-1], cur_q});
  assign dmag       = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);
  assign sweeps_inc = sweeps + 16'd1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size     <= SIZE_RST;
      method          <= 1'b0;
      tolerance       <= TOL_RST;
      iteration_limit <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SIZE:      matrix_size     <= cfg_data[3:0];
        REG_METHOD:    method          <= cfg_data[0];
        REG_TOLERANCE: tolerance       <= cfg_data;
        REG_LIMIT:     iteration_limit <= cfg_data[15:0];
        default:       method          <= method;
      endcase
    end
  end

  // Solve sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      sweeps   <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_op == OP_SOLVE)) begin
            n_act  <= n_eff;
            k      <= '0;
            zdiag  <= 1'b0;
            sweeps <= '0;
            state  <= S_DIAG;
          end
        end
        S_DIAG: begin
          state <= S_DIAG_CHK;
        end
        S_DIAG_CHK: begin
          if (coef_q == '0) begin
            zdiag <= 1'b1;
          end
          if (k == n_act - 1'b1) begin
            if (zdiag || (coef_q == '0)) begin
              status <= ST_ZERO_DIAG;
              k      <= '0;
              state  <= S_OUT_RD;
            end else begin
              i      <= '0;
              change <= '0;
              state  <= S_ROW;
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_DIAG;
          end
        end
        S_ROW: begin
          j     <= '0;
          sum   <= '0;
          state <= S_TERM_RD;
        end
        S_TERM_RD: begin
          state <= S_TERM_MUL;
        end
        S_TERM_MUL: begin
          is_diag <= (j == i);
          if (j == i) begin
            diag <= coef_q;
          end
          prod  <= $signed(coef_q) * $signed(est_q);
          state <= S_TERM_ACC;
        end
        S_TERM_ACC: begin
          // Floor the scaled product and add it in unless it is the diagonal term.
          if (!is_diag) begin
            sum <= sum + SUM_W'(prod >>> FRAC_BITS);
          end
          if (j == n_act - 1'b1) begin
            state <= S_DIV_GO;
          end else begin
            j     <= j + 1'b1;
            state <= S_TERM_RD;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (i == n_act - 1'b1) begin
              k     <= '0;
              state <= S_CP_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_ROW;
            end
          end
        end
        S_CP_RD: begin
          state <= S_CP_WR;
        end
        S_CP_WR: begin
          if (dmag > change) begin
            change <= dmag;
          end
          if (k == n_act - 1'b1) begin
            state <= S_TEST;
          end else begin
            k     <= k + 1'b1;
            state <= S_CP_RD;
          end
        end
        S_TEST: begin
          sweeps <= sweeps_inc;
          k      <= '0;
          if (change <= {2'b00, tolerance}) begin
            status <= ST_CONVERGED;
            state  <= S_OUT_RD;
          end else if (sweeps_inc >= iteration_limit) begin
            status <= ST_LIMIT;
            state  <= S_OUT_RD;
          end else begin
            i      <= '0;
            change <= '0;
            state  <= S_ROW;
          end
        end
        S_OUT_RD: begin
          if (!m_tvalid || m_tready) begin
            state <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          out_index  <= 3'(k);
          out_sol    <= cur_q;
          out_sweeps <= sweeps;
          out_status <= status;
          out_last   <= (k == n_act - 1'b1);
          m_tvalid   <= 1'b1;
          if (k == n_act - 1'b1) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output transaction packing.
  assign m_tdata = {5'b00000, out_sweeps, out_sol, out_index};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // Checks on the sequencer.
  `ILS_ASSERT(a_term_in_range, clk, rst, (state == S_TERM_RD) |-> (j < n_act && i < n_act), "term index beyond matrix size")
  `ILS_ASSERT(a_div_done_wait, clk, rst, div_done |-> (state == S_DIV_WAIT), "divider finished outside its wait state")
  `ILS_ASSERT_NEVER(a_zero_diag_sweeps, clk, rst, m_tvalid && m_tuser == ST_ZERO_DIAG && out_sweeps != 16'd0, "zero-diagonal result reports sweeps")

endmodule
